// ----- hw/rtl/plcl_pkg.sv -----
// Package for the piecewise-linear color table: item types, kind codes,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
package plcl_pkg;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_CLEAR  = 2'd2,
    KIND_LOOKUP = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  key;
    logic [31:0] point_color;
  } in_item_t;

  typedef struct packed {
    logic [31:0] table_color;
    logic        is_lookup;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PREAD,
    ST_SEGINIT,
    ST_MUL,
    ST_LOAD,
    ST_DIV,
    ST_WR,
    ST_SEGEND,
    ST_LRD,
    ST_LDATA
  } state_e;

  typedef struct packed {
    logic pt_write;
    logic pt_remove;
    logic pt_clear;
    logic latch_key;
    logic scan_init;
    logic sk_inc;
    logic rgba_re;
    logic cto_load_pt;
    logic cto_load_end;
    logic seg_init;
    logic mul;
    logic div_load;
    logic div_step;
    logic entry_write;
    logic seg_end;
    logic tbl_re;
    logic out_load_lookup;
    logic out_load_zero;
  } cmd_t;

  typedef struct packed {
    logic cur_present;
    logic sk_last;
    logic f_last;
    logic d_zero;
    logic bit_zero;
    logic k_last;
    logic seg_done;
  } status_t;

endpackage

// ----- hw/rtl/plcl_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module plcl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/plcl_ctrl.sv -----
// Controller of the color table: item handshake, stale flag, rebuild sequencer.
// Depends on plcl_pkg.
module plcl_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  plcl_pkg::kind_e   kind_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  plcl_pkg::status_t status_i,
  output plcl_pkg::cmd_t    cmd_o
);
  import plcl_pkg::*;

  state_e state_q, state_d;
  logic   stale_q, stale_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  assign in_stall_o = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    stale_d = stale_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (kind_i)
            KIND_INSERT: begin
              cmd_o.pt_write      = 1'b1;
              cmd_o.out_load_zero = 1'b1;
              stale_d             = 1'b1;
            end
            KIND_REMOVE: begin
              cmd_o.pt_remove     = 1'b1;
              cmd_o.out_load_zero = 1'b1;
              stale_d             = 1'b1;
            end
            KIND_CLEAR: begin
              cmd_o.pt_clear      = 1'b1;
              cmd_o.out_load_zero = 1'b1;
              stale_d             = 1'b1;
            end
            KIND_LOOKUP: begin
              cmd_o.latch_key = 1'b1;
              if (stale_q) begin
                cmd_o.scan_init = 1'b1;
                state_d         = ST_SCAN;
              end else begin
                state_d = ST_LRD;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (status_i.cur_present) begin
          cmd_o.rgba_re = 1'b1;
          state_d       = ST_PREAD;
        end else if (status_i.sk_last) begin
          if (status_i.f_last) begin
            stale_d = 1'b0;
            state_d = ST_LRD;
          end else begin
            cmd_o.cto_load_end = 1'b1;
            state_d            = ST_SEGINIT;
          end
        end else begin
          cmd_o.sk_inc = 1'b1;
        end
      end
      ST_PREAD: begin
        cmd_o.cto_load_pt = 1'b1;
        state_d           = ST_SEGINIT;
      end
      ST_SEGINIT: begin
        cmd_o.seg_init = 1'b1;
        state_d        = ST_MUL;
      end
      ST_MUL: begin
        if (status_i.d_zero) begin
          state_d = ST_SEGEND;
        end else begin
          cmd_o.mul = 1'b1;
          state_d   = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd_o.div_load = 1'b1;
        state_d        = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.bit_zero) begin
          state_d = ST_WR;
        end
      end
      ST_WR: begin
        cmd_o.entry_write = 1'b1;
        state_d = status_i.k_last ? ST_SEGEND : ST_LOAD;
      end
      ST_SEGEND: begin
        cmd_o.seg_end = 1'b1;
        if (status_i.seg_done) begin
          stale_d = 1'b0;
          state_d = ST_LRD;
        end else begin
          cmd_o.sk_inc = 1'b1;
          state_d      = ST_SCAN;
        end
      end
      ST_LRD: begin
        cmd_o.tbl_re = 1'b1;
        state_d      = ST_LDATA;
      end
      ST_LDATA: begin
        cmd_o.out_load_lookup = 1'b1;
        state_d               = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load_zero || cmd_o.out_load_lookup) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      stale_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      stale_q     <= stale_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- hw/rtl/plcl_dp.sv -----
// Datapath of the color table: presence map, point and table memories,
// segment walker, four-channel bit-serial interpolation divider, result register.
// Depends on plcl_pkg and plcl_ram.
module plcl_dp #(
  parameter int KEY_COUNT = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  plcl_pkg::cmd_t      cmd_i,
  input  plcl_pkg::in_item_t  in_item_i,
  output plcl_pkg::status_t   status_o,
  output plcl_pkg::out_item_t out_item_o
);
  import plcl_pkg::*;

  localparam int PD  = (KEY_COUNT < 256) ? KEY_COUNT : 256;
  localparam int PAW = $clog2(PD);
  localparam int KW  = $clog2(KEY_COUNT);
  localparam int TD  = KEY_COUNT - 1;
  localparam int TAW = $clog2(TD);
  localparam int NW  = KW + 8;

  logic [PD-1:0]  present_q;
  logic [KW-1:0]  sk_q, f_q, b_q, d_q, k_q;
  logic [TAW-1:0] lk_q;
  logic [31:0]    cfrom_q, cto_q;
  logic           is_end_q;
  logic [2:0]     bit_q;
  logic [NW-1:0]  n_q [4];
  logic [NW-1:0]  r_q [4];
  logic [7:0]     q_q [4];
  out_item_t      out_q;

  logic           key_in_range;
  logic [31:0]    key32;
  logic [31:0]    rgba_rdata, tbl_rdata, tbl_wdata;
  logic [KW-1:0]  taddr;
  logic [KW:0]    k_next;
  logic [NW-1:0]  dsh;

  assign key32        = 32'(in_item_i.key);
  assign key_in_range = key32 < KEY_COUNT;
  assign taddr        = f_q + k_q;
  assign k_next       = {1'b0, k_q} + 1'b1;
  assign dsh          = NW'(d_q) << bit_q;
  assign tbl_wdata    = {q_q[3], q_q[2], q_q[1], q_q[0]};

  assign status_o.cur_present = (32'(sk_q) < PD) && present_q[sk_q[PAW-1:0]];
  assign status_o.sk_last     = sk_q == KW'(KEY_COUNT - 1);
  assign status_o.f_last      = f_q == KW'(KEY_COUNT - 1);
  assign status_o.d_zero      = d_q == '0;
  assign status_o.bit_zero    = bit_q == '0;
  assign status_o.k_last      = k_next == {1'b0, d_q};
  assign status_o.seg_done    = is_end_q || (sk_q == KW'(KEY_COUNT - 1));

  plcl_ram #(.WIDTH(32), .DEPTH(PD)) u_rgba (
    .clk_i   (clk_i),
    .we_i    (cmd_i.pt_write && key_in_range),
    .waddr_i (in_item_i.key[PAW-1:0]),
    .wdata_i (in_item_i.point_color),
    .re_i    (cmd_i.rgba_re),
    .raddr_i (sk_q[PAW-1:0]),
    .rdata_o (rgba_rdata)
  );

  plcl_ram #(.WIDTH(32), .DEPTH(TD)) u_table (
    .clk_i   (clk_i),
    .we_i    (cmd_i.entry_write),
    .waddr_i (taddr[TAW-1:0]),
    .wdata_i (tbl_wdata),
    .re_i    (cmd_i.tbl_re),
    .raddr_i (lk_q),
    .rdata_o (tbl_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= '0;
    end else if (cmd_i.pt_clear) begin
      present_q <= '0;
    end else if (key_in_range && (cmd_i.pt_write || cmd_i.pt_remove)) begin
      present_q[in_item_i.key[PAW-1:0]] <= cmd_i.pt_write;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_key) begin
      lk_q <= (key32 > KEY_COUNT - 2) ? TAW'(KEY_COUNT - 2) : key32[TAW-1:0];
    end
    if (cmd_i.scan_init) begin
      sk_q     <= '0;
      f_q      <= '0;
      cfrom_q  <= '0;
      is_end_q <= 1'b0;
    end else if (cmd_i.sk_inc) begin
      sk_q <= sk_q + 1'b1;
    end
    if (cmd_i.cto_load_pt) begin
      cto_q    <= rgba_rdata;
      b_q      <= sk_q;
      is_end_q <= 1'b0;
    end else if (cmd_i.cto_load_end) begin
      cto_q    <= '0;
      b_q      <= KW'(KEY_COUNT - 1);
      is_end_q <= 1'b1;
    end
    if (cmd_i.seg_init) begin
      d_q <= b_q - f_q;
      k_q <= '0;
    end else if (cmd_i.entry_write) begin
      k_q <= k_next[KW-1:0];
    end
    if (cmd_i.seg_end) begin
      f_q     <= b_q;
      cfrom_q <= cto_q;
    end
    if (cmd_i.div_load) begin
      bit_q <= 3'd7;
    end else if (cmd_i.div_step) begin
      bit_q <= bit_q - 1'b1;
    end
    for (int c = 0; c < 4; c++) begin
      if (cmd_i.mul) begin
        n_q[c] <= NW'(d_q) * NW'(cfrom_q[8*c +: 8]);
      end else if (cmd_i.entry_write) begin
        n_q[c] <= n_q[c] + NW'($signed({1'b0, cto_q[8*c +: 8]})
                              - $signed({1'b0, cfrom_q[8*c +: 8]}));
      end
      if (cmd_i.div_load) begin
        r_q[c] <= n_q[c];
        q_q[c] <= '0;
      end else if (cmd_i.div_step && (r_q[c] >= dsh)) begin
        r_q[c]        <= r_q[c] - dsh;
        q_q[c][bit_q] <= 1'b1;
      end
    end
    if (cmd_i.out_load_zero) begin
      out_q <= '0;
    end else if (cmd_i.out_load_lookup) begin
      out_q.table_color <= tbl_rdata;
      out_q.is_lookup   <= 1'b1;
    end
  end

  assign out_item_o = out_q;

endmodule

// ----- hw/rtl/piecewise_linear_color_lut.sv -----
// Top level of the piecewise-linear RGBA color table.
// Depends on plcl_pkg, plcl_ctrl, plcl_dp (and plcl_ram through plcl_dp).
//
// Input items (in_item_i) insert a keyed RGBA point, remove one, clear all, or
// look up the interpolated table. Every item gives exactly one result item on
// out_item_o: table_color and is_lookup set for a lookup, all zero otherwise.
// Both channels move an item at a clock edge with valid high and stall low.
// For insert, remove and clear the result is shown in the next cycle, and the
// next item is taken in the same cycle the result leaves.
// A lookup on a clean table reads the table memory, then loads the result.
// After any edit the first lookup rebuilds the table first: it scans every key,
// reads the color of each present point and fills each table entry with a
// bit-serial divider that yields one quotient bit per cycle for all channels.
// in_stall_o stays high meanwhile.
// A stalled result holds the output register and, with it, the input side.
// Reset empties the point set and marks the table stale; the point and table
// memories need no clearing pass.
module piecewise_linear_color_lut #(
  parameter int KEY_COUNT = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  plcl_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output plcl_pkg::out_item_t out_item_o
);
  import plcl_pkg::*;

  cmd_t    cmd;
  status_t status;

  plcl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (in_item_i.kind),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  plcl_dp #(.KEY_COUNT(KEY_COUNT)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_item_i  (in_item_i),
    .status_o   (status),
    .out_item_o (out_item_o)
  );

  a_edit_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_item_i.kind != KIND_LOOKUP)
      |=> (out_valid_o && !out_item_o.is_lookup && out_item_o.table_color == '0))
    else $error("edit item did not give a zero result");

  a_lookup_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_item_i.kind == KIND_LOOKUP) |=> in_stall_o)
    else $error("input taken while a lookup is in flight");

  a_rebuild_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.entry_write |-> in_stall_o)
    else $error("input open during table rebuild");

endmodule
